// File: hw/rtl/mlbc_pkg.sv
// ----------------------------------------------------------------------------
// mlbc_pkg
// Shared types and constants of the multi-LED blink controller: item kinds,
// field widths and the command/status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package mlbc_pkg;

    localparam int unsigned KIND_W   = 2;
    localparam int unsigned INDEX_W  = 4;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned MASK_W   = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_SET    = 2'd0,
        KIND_TOGGLE = 2'd1,
        KIND_BLINK  = 2'd2,
        KIND_TICK   = 2'd3
    } t_kind;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic apply;       // apply a set, toggle or blink command beat
        logic tick_start;  // advance time, clear change flag, rewind LED pointer
        logic step;        // service the LED under the pointer, advance pointer
        logic emit;        // load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last_led;    // pointer sits on the highest LED
    } t_dp_sts;

endpackage

// File: hw/rtl/mlbc_ctrl.sv
// ----------------------------------------------------------------------------
// mlbc_ctrl
// Sequencer of the blink controller: takes one beat at a time, walks the
// LEDs on a tick and hands the result to the output register.
// ----------------------------------------------------------------------------
module mlbc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_kind,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mlbc_pkg::t_dp_cmd o_cmd,
    input  mlbc_pkg::t_dp_sts i_sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_accept;
    logic   w_is_tick;
    logic   w_emit;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_is_tick   = (i_kind == mlbc_pkg::KIND_TICK);
    assign w_emit      = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    // Drive datapath commands
    always_comb begin
        o_cmd.apply      = w_accept && !w_is_tick;
        o_cmd.tick_start = w_accept && w_is_tick;
        o_cmd.step       = (r_state == S_WALK);
        o_cmd.emit       = w_emit;
    end

    // Hold state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= w_is_tick ? S_WALK : S_EMIT;
                    end
                end
                S_WALK: begin
                    if (i_sts.last_led) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_emit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: hw/rtl/mlbc_dp.sv
// ----------------------------------------------------------------------------
// mlbc_dp
// Datapath of the blink controller: per-LED state, the millisecond counter,
// the LED pointer with its elapsed-time compare, and the result register.
// ----------------------------------------------------------------------------
module mlbc_dp #(
    parameter int unsigned LED_COUNT = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mlbc_pkg::t_dp_cmd               i_cmd,
    output mlbc_pkg::t_dp_sts               o_sts,
    input  logic [1:0]                      i_kind,
    input  logic [mlbc_pkg::INDEX_W-1:0]    i_led_index,
    input  logic                            i_on_value,
    input  logic                            i_blink_enable,
    input  logic [mlbc_pkg::PERIOD_W-1:0]   i_period_ms,
    output logic [mlbc_pkg::MASK_W-1:0]     o_pin_mask,
    output logic                            o_pins_changed
);

    localparam int unsigned PTR_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int unsigned PAD_W = (LED_COUNT > mlbc_pkg::MASK_W) ?
                                    LED_COUNT : mlbc_pkg::MASK_W;

    logic [LED_COUNT-1:0]          r_lit;
    logic [LED_COUNT-1:0]          r_blinking;
    logic [LED_COUNT-1:0]          r_driven;
    logic [mlbc_pkg::PERIOD_W-1:0] r_period [LED_COUNT];
    logic [mlbc_pkg::TIME_W-1:0]   r_last   [LED_COUNT];
    logic [mlbc_pkg::TIME_W-1:0]   r_now;
    logic [PTR_W-1:0]              r_ptr;
    logic                          r_changed;
    logic [mlbc_pkg::MASK_W-1:0]   r_pin_mask;
    logic                          r_pins_changed;

    logic                          w_idx_ok;
    logic [PTR_W-1:0]              w_idx;
    logic [mlbc_pkg::TIME_W-1:0]   w_elapsed;
    logic [mlbc_pkg::TIME_W-1:0]   w_half;
    logic                          w_flip;
    logic                          w_new_lit;
    logic [PAD_W-1:0]              w_drv_pad;

    assign w_idx_ok = ({1'b0, i_led_index} < (mlbc_pkg::INDEX_W+1)'(LED_COUNT));
    assign w_idx    = PTR_W'(i_led_index);

    // Elapsed time of the LED under the pointer against half its period
    assign w_elapsed = r_now - r_last[r_ptr];
    assign w_half    = mlbc_pkg::TIME_W'(r_period[r_ptr] >> 1);
    assign w_flip    = r_blinking[r_ptr] && (r_period[r_ptr] != '0) &&
                       (w_elapsed >= w_half);
    assign w_new_lit = r_lit[r_ptr] ^ w_flip;

    assign o_sts.last_led = (r_ptr == PTR_W'(LED_COUNT - 1));

    assign w_drv_pad = PAD_W'(r_driven);

    // Per-LED state and time base
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lit      <= '0;
            r_blinking <= '0;
            r_driven   <= '0;
            r_now      <= '0;
            r_ptr      <= '0;
            r_changed  <= 1'b0;
            for (int i = 0; i < LED_COUNT; i++) begin
                r_period[i] <= '0;
                r_last[i]   <= '0;
            end
        end else begin
            if (i_cmd.tick_start) begin
                r_now     <= r_now + 1'b1;
                r_ptr     <= '0;
            end

            // Start every beat with a clean change flag
            if (i_cmd.tick_start || i_cmd.apply) begin
                r_changed <= 1'b0;
            end

            // Apply a command beat to the addressed LED
            if (i_cmd.apply && w_idx_ok) begin
                unique case (i_kind)
                    mlbc_pkg::KIND_SET: begin
                        r_blinking[w_idx] <= 1'b0;
                        r_lit[w_idx]      <= i_on_value;
                    end
                    mlbc_pkg::KIND_TOGGLE: begin
                        r_blinking[w_idx] <= 1'b0;
                        r_lit[w_idx]      <= ~r_lit[w_idx];
                    end
                    mlbc_pkg::KIND_BLINK: begin
                        if (i_period_ms != '0) begin
                            if (i_blink_enable) begin
                                r_blinking[w_idx] <= 1'b1;
                                r_lit[w_idx]      <= 1'b1;
                                r_period[w_idx]   <= i_period_ms;
                                r_last[w_idx]     <= r_now;
                            end else begin
                                r_blinking[w_idx] <= 1'b0;
                            end
                        end
                    end
                    default: ;
                endcase
            end

            // Service one LED per cycle of the tick walk
            if (i_cmd.step) begin
                if (w_flip) begin
                    r_lit[r_ptr]  <= w_new_lit;
                    r_last[r_ptr] <= r_now;
                end
                if (r_driven[r_ptr] != w_new_lit) begin
                    r_driven[r_ptr] <= w_new_lit;
                    r_changed       <= 1'b1;
                end
                if (!o_sts.last_led) begin
                    r_ptr <= r_ptr + 1'b1;
                end
            end
        end
    end

    // Capture the result beat; a command beat never moves a pin
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_pin_mask     <= w_drv_pad[mlbc_pkg::MASK_W-1:0];
            r_pins_changed <= r_changed;
        end
    end

    assign o_pin_mask     = r_pin_mask;
    assign o_pins_changed = r_pins_changed;

endmodule

// File: hw/rtl/multi_led_blink_controller.sv
// ----------------------------------------------------------------------------
// multi_led_blink_controller
// Set/toggle/blink control of LED_COUNT LEDs on a millisecond time base.
// ----------------------------------------------------------------------------
// One input beat is taken at a time and gives exactly one result beat (pin
// levels of LEDs 0..3 and a pins-changed flag). A set, toggle or blink beat
// updates the addressed LED in the accept cycle; its result waits in the
// emit state until the output register is free. A tick beat walks the
// LEDs one per cycle through a single elapsed-time compare and then emits
// its result the same way. Pins follow the requested levels only on a tick.
// The input side is ready again once the result has moved into the output
// register, which holds it until taken.
module multi_led_blink_controller #(
    parameter int unsigned LED_COUNT = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [mlbc_pkg::KIND_W-1:0]   i_kind,
    input  logic [mlbc_pkg::INDEX_W-1:0]  i_led_index,
    input  logic                          i_on_value,
    input  logic                          i_blink_enable,
    input  logic [mlbc_pkg::PERIOD_W-1:0] i_period_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mlbc_pkg::MASK_W-1:0]   o_pin_mask,
    output logic                          o_pins_changed
);

    mlbc_pkg::t_dp_cmd w_cmd;
    mlbc_pkg::t_dp_sts w_sts;

    mlbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    mlbc_dp #(
        .LED_COUNT (LED_COUNT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_kind         (i_kind),
        .i_led_index    (i_led_index),
        .i_on_value     (i_on_value),
        .i_blink_enable (i_blink_enable),
        .i_period_ms    (i_period_ms),
        .o_pin_mask     (o_pin_mask),
        .o_pins_changed (o_pins_changed)
    );

endmodule

// File: hw/rtl/mlbc_chk.sv
// ----------------------------------------------------------------------------
// mlbc_chk
// Port-level checks of the blink controller, bound to the top level.
// ----------------------------------------------------------------------------
module mlbc_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [mlbc_pkg::MASK_W-1:0]   o_pin_mask,
    input logic                          o_pins_changed
);

    // Drop the result valid out of reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid high after reset");

    // Take only one beat at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready stayed high after an accepted beat");

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_pin_mask) && $stable(o_pins_changed)))
        else $error("stalled result beat changed");

endmodule

bind multi_led_blink_controller mlbc_chk u_mlbc_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_pin_mask     (o_pin_mask),
    .o_pins_changed (o_pins_changed)
);

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multi-LED blink controller. A short table of
// directed beats covers reset, field extremes, ignored commands, the zero
// period and both blink half-period roundings, then random beats are
// weighted toward blink commands with short periods and ticks so that LEDs
// really blink. Every accepted input beat advances an in-bench model of the
// LED state, and each result beat is checked against the oldest expectation.
// Both channels idle and stall in several phases.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned LED_COUNT      = 4;
    localparam int          RANDOM_ITEMS   = 625;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          DIR_ROWS       = 25;

    // Idle and stall percentages per random phase
    localparam int SEND_IDLE  [4] = '{0, 77, 0, 8};
    localparam int RECV_STALL [4] = '{0, 0, 77, 8};

    typedef struct packed {
        logic [mlbc_pkg::MASK_W-1:0] mask;
        logic                        changed;
    } t_pin_result;

    typedef struct packed {
        mlbc_pkg::t_kind               kind;
        logic [mlbc_pkg::INDEX_W-1:0]  idx;
        logic                          on;
        logic                          en;
        logic [mlbc_pkg::PERIOD_W-1:0] per;
        logic                          has_exp;
        logic [mlbc_pkg::MASK_W-1:0]   exp_mask;
        logic                          exp_changed;
    } t_dir_row;

    // Directed beats; typed results only where they are obvious
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{mlbc_pkg::KIND_TICK,   4'd0,  1'b0, 1'b0, 16'h0000, 1'b1, 4'h0, 1'b0},
        '{mlbc_pkg::KIND_SET,    4'd0,  1'b1, 1'b0, 16'h0000, 1'b1, 4'h0, 1'b0},
        '{mlbc_pkg::KIND_TICK,   4'd0,  1'b0, 1'b0, 16'h0000, 1'b1, 4'h1, 1'b1},
        '{mlbc_pkg::KIND_SET,    4'd3,  1'b1, 1'b0, 16'h0000, 1'b1, 4'h1, 1'b0},
        '{mlbc_pkg::KIND_TOGGLE, 4'd1,  1'b0, 1'b0, 16'h0000, 1'b1, 4'h1, 1'b0},
        '{mlbc_pkg::KIND_TICK,   4'd15, 1'b1, 1'b1, 16'hFFFF, 1'b1, 4'hB, 1'b1},
        '{mlbc_pkg::KIND_SET,    4'd15, 1'b1, 1'b0, 16'h0000, 1'b1, 4'hB, 1'b0},
        '{mlbc_pkg::KIND_TOGGLE, 4'd4,  1'b0, 1'b0, 16'h0000, 1'b1, 4'hB, 1'b0},
        '{mlbc_pkg::KIND_BLINK,  4'd2,  1'b0, 1'b1, 16'h0000, 1'b1, 4'hB, 1'b0},
        '{mlbc_pkg::KIND_TICK,   4'd0,  1'b0, 1'b0, 16'h0000, 1'b1, 4'hB, 1'b0},
        '{mlbc_pkg::KIND_BLINK,  4'd2,  1'b0, 1'b1, 16'hFFFF, 1'b1, 4'hB, 1'b0},
        '{mlbc_pkg::KIND_TICK,   4'd0,  1'b0, 1'b0, 16'h0000, 1'b1, 4'hF, 1'b1},
        '{mlbc_pkg::KIND_BLINK,  4'd2,  1'b1, 1'b0, 16'hFFFF, 1'b1, 4'hF, 1'b0},
        '{mlbc_pkg::KIND_SET,    4'd0,  1'b0, 1'b1, 16'hFFFF, 1'b1, 4'hF, 1'b0},
        '{mlbc_pkg::KIND_TICK,   4'd0,  1'b0, 1'b0, 16'h0000, 1'b1, 4'hE, 1'b1},
        '{mlbc_pkg::KIND_BLINK,  4'd1,  1'b0, 1'b1, 16'h0001, 1'b1, 4'hE, 1'b0},
        '{mlbc_pkg::KIND_TICK,   4'd0,  1'b0, 1'b0, 16'h0000, 1'b1, 4'hC, 1'b1},
        '{mlbc_pkg::KIND_TICK,   4'd0,  1'b0, 1'b0, 16'h0000, 1'b1, 4'hE, 1'b1},
        '{mlbc_pkg::KIND_BLINK,  4'd3,  1'b0, 1'b1, 16'h0002, 1'b0, 4'h0, 1'b0},
        '{mlbc_pkg::KIND_TICK,   4'd0,  1'b0, 1'b0, 16'h0000, 1'b0, 4'h0, 1'b0},
        '{mlbc_pkg::KIND_TICK,   4'd0,  1'b0, 1'b0, 16'h0000, 1'b0, 4'h0, 1'b0},
        '{mlbc_pkg::KIND_TICK,   4'd0,  1'b0, 1'b0, 16'h0000, 1'b0, 4'h0, 1'b0},
        '{mlbc_pkg::KIND_BLINK,  4'd1,  1'b0, 1'b0, 16'h0000, 1'b0, 4'h0, 1'b0},
        '{mlbc_pkg::KIND_BLINK,  4'd1,  1'b0, 1'b0, 16'h8000, 1'b0, 4'h0, 1'b0},
        '{mlbc_pkg::KIND_TICK,   4'd0,  1'b0, 1'b0, 16'h0000, 1'b0, 4'h0, 1'b0}
    };

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic [mlbc_pkg::KIND_W-1:0]   i_kind;
    logic [mlbc_pkg::INDEX_W-1:0]  i_led_index;
    logic                          i_on_value;
    logic                          i_blink_enable;
    logic [mlbc_pkg::PERIOD_W-1:0] i_period_ms;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic [mlbc_pkg::MASK_W-1:0]   o_pin_mask;
    logic                          o_pins_changed;

    // Model state of the LEDs and the time base
    logic                          lit_m        [LED_COUNT];
    logic                          blinking_m   [LED_COUNT];
    logic                          driven_m     [LED_COUNT];
    logic [mlbc_pkg::PERIOD_W-1:0] period_m     [LED_COUNT];
    logic [mlbc_pkg::TIME_W-1:0]   toggled_at_m [LED_COUNT];
    logic [mlbc_pkg::TIME_W-1:0]   now_ms_m;

    t_pin_result pin_expect_q [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int tick_count     = 0;
    int command_count  = 0;
    int ignored_count  = 0;
    int blink_starts   = 0;
    int pin_moves      = 0;

    multi_led_blink_controller #(
        .LED_COUNT(LED_COUNT)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_led_index    (i_led_index),
        .i_on_value     (i_on_value),
        .i_blink_enable (i_blink_enable),
        .i_period_ms    (i_period_ms),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pin_mask     (o_pin_mask),
        .o_pins_changed (o_pins_changed)
    );

    always #1 i_clk = ~i_clk;

    // Advance the LED model by one input beat and return the pins it leaves
    function automatic t_pin_result advance_leds(mlbc_pkg::t_kind kind,
                                                 logic [mlbc_pkg::INDEX_W-1:0] idx,
                                                 logic on, logic en,
                                                 logic [mlbc_pkg::PERIOD_W-1:0] per);
        t_pin_result                 res;
        logic [mlbc_pkg::TIME_W-1:0] elapsed;
        res = '0;
        if (kind == mlbc_pkg::KIND_TICK) begin
            now_ms_m = now_ms_m + 1'b1;
            for (int i = 0; i < LED_COUNT; i++) begin
                if (blinking_m[i] && period_m[i] != '0) begin
                    elapsed = now_ms_m - toggled_at_m[i];
                    if (elapsed >= mlbc_pkg::TIME_W'(period_m[i] >> 1)) begin
                        lit_m[i]        = ~lit_m[i];
                        toggled_at_m[i] = now_ms_m;
                    end
                end
                if (driven_m[i] != lit_m[i]) begin
                    driven_m[i] = lit_m[i];
                    res.changed = 1'b1;
                end
            end
        end else if (idx < LED_COUNT) begin
            case (kind)
                mlbc_pkg::KIND_SET: begin
                    blinking_m[idx] = 1'b0;
                    lit_m[idx]      = on;
                end
                mlbc_pkg::KIND_TOGGLE: begin
                    blinking_m[idx] = 1'b0;
                    lit_m[idx]      = ~lit_m[idx];
                end
                default: begin
                    if (per != '0) begin
                        if (en) begin
                            blinking_m[idx]   = 1'b1;
                            lit_m[idx]        = 1'b1;
                            period_m[idx]     = per;
                            toggled_at_m[idx] = now_ms_m;
                        end else begin
                            blinking_m[idx] = 1'b0;
                        end
                    end
                end
            endcase
        end
        for (int i = 0; i < LED_COUNT && i < mlbc_pkg::MASK_W; i++) begin
            res.mask[i] = driven_m[i];
        end
        return res;
    endfunction

    // Offer one input beat, hold it until taken, then queue its expected result
    task automatic send_item(mlbc_pkg::t_kind kind, logic [mlbc_pkg::INDEX_W-1:0] idx,
                             logic on, logic en, logic [mlbc_pkg::PERIOD_W-1:0] per,
                             logic has_exp, t_pin_result typed);
        t_pin_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_kind         <= kind;
        i_led_index    <= idx;
        i_on_value     <= on;
        i_blink_enable <= en;
        i_period_ms    <= per;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = advance_leds(kind, idx, on, en, per);
        pin_expect_q.push_back(has_exp ? typed : predicted);
        if (kind == mlbc_pkg::KIND_TICK) begin
            tick_count++;
        end else if (idx >= LED_COUNT || (kind == mlbc_pkg::KIND_BLINK && per == '0)) begin
            ignored_count++;
        end else begin
            command_count++;
            if (kind == mlbc_pkg::KIND_BLINK && en) begin
                blink_starts++;
            end
        end
    endtask

    // Stall the result channel at random
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check each result beat against the oldest expectation
    always @(posedge i_clk) begin
        t_pin_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pin_expect_q.size() == 0) begin
                $display("%0t: unexpected result beat, mask %h changed %b",
                         $time, o_pin_mask, o_pins_changed);
                mismatch_count++;
            end else begin
                want = pin_expect_q.pop_front();
                if (o_pin_mask !== want.mask) begin
                    $display("%0t: pin_mask expected %h, got %h",
                             $time, want.mask, o_pin_mask);
                    mismatch_count++;
                end
                if (o_pins_changed !== want.changed) begin
                    $display("%0t: pins_changed expected %b, got %b",
                             $time, want.changed, o_pins_changed);
                    mismatch_count++;
                end
                if (o_pins_changed === 1'b1) begin
                    pin_moves++;
                end
            end
        end
    end

    // End the run when no beat moves on either channel for too long
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("%0t: watchdog expired, %0d cycles without a beat, %0d results pending",
                 $time, WATCHDOG_LIMIT, pin_expect_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int                            counted;
        int                            phase_goal;
        int                            pick;
        mlbc_pkg::t_kind               kind;
        logic [mlbc_pkg::INDEX_W-1:0]  idx;
        logic                          on;
        logic                          en;
        logic [mlbc_pkg::PERIOD_W-1:0] per;
        t_pin_result                   typed;

        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_kind         <= mlbc_pkg::KIND_SET;
        i_led_index    <= '0;
        i_on_value     <= 1'b0;
        i_blink_enable <= 1'b0;
        i_period_ms    <= '0;
        for (int i = 0; i < LED_COUNT; i++) begin
            lit_m[i]        = 1'b0;
            blinking_m[i]   = 1'b0;
            driven_m[i]     = 1'b0;
            period_m[i]     = '0;
            toggled_at_m[i] = '0;
        end
        now_ms_m = '0;
        counted  = 0;

        // Hold reset, then release
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table with no idling
        for (int r = 0; r < DIR_ROWS; r++) begin
            typed.mask    = DIR_TABLE[r].exp_mask;
            typed.changed = DIR_TABLE[r].exp_changed;
            send_item(DIR_TABLE[r].kind, DIR_TABLE[r].idx, DIR_TABLE[r].on,
                      DIR_TABLE[r].en, DIR_TABLE[r].per, DIR_TABLE[r].has_exp, typed);
        end

        // Random beats, weighted toward blinking and ticks
        typed = '0;
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = SEND_IDLE[ph];
            recv_stall_pct = RECV_STALL[ph];
            if (ph == 2) begin
                // Hold off until every pending result has drained
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (pin_expect_q.size() != 0);
            end
            phase_goal = (ph + 1) * RANDOM_ITEMS / 4;
            while (counted < phase_goal) begin
                kind = mlbc_pkg::t_kind'($urandom_range(3));
                idx  = mlbc_pkg::INDEX_W'($urandom);
                on   = 1'($urandom);
                en   = 1'($urandom);
                per  = mlbc_pkg::PERIOD_W'($urandom);
                pick = $urandom_range(99);
                if (pick < 45) begin
                    kind = mlbc_pkg::KIND_TICK;
                end else if (pick < 60) begin
                    kind = mlbc_pkg::KIND_BLINK;
                    idx  = mlbc_pkg::INDEX_W'($urandom_range(LED_COUNT - 1));
                    en   = 1'b1;
                    per  = ($urandom_range(7) == 0) ?
                           mlbc_pkg::PERIOD_W'($urandom_range(65535, 1)) :
                           mlbc_pkg::PERIOD_W'($urandom_range(12, 1));
                end else if (pick < 68) begin
                    kind = mlbc_pkg::KIND_BLINK;
                    idx  = mlbc_pkg::INDEX_W'($urandom_range(LED_COUNT - 1));
                    en   = 1'b0;
                    per  = mlbc_pkg::PERIOD_W'($urandom_range(65535, 1));
                end else if (pick < 80) begin
                    kind = mlbc_pkg::KIND_SET;
                    idx  = mlbc_pkg::INDEX_W'($urandom_range(LED_COUNT - 1));
                end else if (pick < 90) begin
                    kind = mlbc_pkg::KIND_TOGGLE;
                    idx  = mlbc_pkg::INDEX_W'($urandom_range(LED_COUNT - 1));
                end else if (pick < 95) begin
                    // Out-of-range index, any command kind
                    kind = mlbc_pkg::t_kind'($urandom_range(2));
                    idx  = mlbc_pkg::INDEX_W'($urandom_range(15, LED_COUNT));
                end else begin
                    // Blink command with a zero period
                    kind = mlbc_pkg::KIND_BLINK;
                    per  = '0;
                end
                send_item(kind, idx, on, en, per, 1'b0, typed);
                counted++;
            end
        end

        // Drain, then allow one tick walk for any stray result
        i_in_valid <= 1'b0;
        while (pin_expect_q.size() != 0) @(posedge i_clk);
        repeat (LED_COUNT + 4) @(posedge i_clk);

        $display("Run covered %0d ticks, %0d LED commands (%0d blink starts), %0d ignored beats.",
                 tick_count, command_count, blink_starts, ignored_count);
        $display("Pins moved on %0d result beats; %0d field mismatches logged.",
                 pin_moves, mismatch_count);
        if (mismatch_count == 0 && pin_expect_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
